FILE: rtl/csv_quoted_field_parser_defines.svh
// Assertion macros shared by the CSV field parser RTL.
`ifndef CSV_QUOTED_FIELD_PARSER_DEFINES_SVH
`define CSV_QUOTED_FIELD_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define CSVP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csvp: same-cycle check failed");
`define CSVP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csvp: next-cycle check failed");
`else
`define CSVP_ASSERT_IMP(lbl, ante, cons)
`define CSVP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/csvp_pkg.sv
// Types and codes shared by the CSV field parser modules.
package csvp_pkg;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_FEND    = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_UNTERM    = 3'd1;
    localparam logic [2:0] ERR_STRAY     = 3'd2;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd3;
    localparam logic [2:0] ERR_AFTER_QT  = 3'd4;
    localparam logic [2:0] ERR_COUNT     = 3'd5;

    localparam logic [4:0]  FIELD_COUNT_RST = 5'd8;
    localparam logic [10:0] MAX_BYTES_RST   = 11'd1024;

    localparam logic REG_FIELD_COUNT = 1'b0;
    localparam logic REG_MAX_BYTES   = 1'b1;

    typedef struct packed {
        logic [4:0]  field_count;
        logic [10:0] max_field_bytes;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       line_valid;
        logic [2:0] error_code;
    } t_result;

endpackage

FILE: rtl/csvp_cfg.sv
// APB register file for the field count and field length limit.
module csvp_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output csvp_pkg::t_cfg     o_cfg
);

    csvp_pkg::t_cfg r_cfg;
    logic           wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_count     <= csvp_pkg::FIELD_COUNT_RST;
            r_cfg.max_field_bytes <= csvp_pkg::MAX_BYTES_RST;
        end else if (wr_en) begin
            case (paddr[2])
                csvp_pkg::REG_FIELD_COUNT: r_cfg.field_count     <= pwdata[4:0];
                csvp_pkg::REG_MAX_BYTES:   r_cfg.max_field_bytes <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            csvp_pkg::REG_FIELD_COUNT: prdata = {27'b0, r_cfg.field_count};
            csvp_pkg::REG_MAX_BYTES:   prdata = {21'b0, r_cfg.max_field_bytes};
            default:                   prdata = '0;
        endcase
    end

endmodule

FILE: rtl/csvp_core.sv
// Per-line parse state and the single-step update for one byte or line end.
module csvp_core #(
    parameter int MAX_FIELDS        = 16,
    parameter int FIELD_BYTES_LIMIT = 2047,
    localparam int IDXW = $clog2(MAX_FIELDS),
    localparam int LW   = $clog2(FIELD_BYTES_LIMIT + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic                i_eol,
    input  csvp_pkg::t_cfg      i_cfg,
    output logic                o_res_valid,
    output csvp_pkg::t_result   o_res,
    output logic [IDXW-1:0]     o_field_index
);

    logic            r_at_start, n_at_start;
    logic            r_inside,   n_inside;
    logic            r_pending,  n_pending;
    logic            r_closed,   n_closed;
    logic [IDXW-1:0] r_field,    n_field;
    logic [LW-1:0]   r_len,      n_len;
    logic [2:0]      r_err,      n_err;

    logic [31:0]     fc_ext;
    logic [31:0]     mfb_ext;
    logic [IDXW-1:0] last_field;
    logic [LW-1:0]   eff_max;
    logic            do_emit;
    logic            do_end;
    logic [2:0]      verdict_err;

    // clamp the configured limits to what the hardware holds
    assign fc_ext     = 32'(i_cfg.field_count);
    assign mfb_ext    = 32'(i_cfg.max_field_bytes);
    assign last_field = (fc_ext == 32'd0) ? '0 :
                        (fc_ext > 32'(MAX_FIELDS)) ? IDXW'(MAX_FIELDS - 1) :
                        IDXW'(fc_ext - 32'd1);
    assign eff_max    = (mfb_ext > 32'(FIELD_BYTES_LIMIT)) ? LW'(FIELD_BYTES_LIMIT) :
                        LW'(mfb_ext);

    always_comb begin
        n_at_start    = r_at_start;
        n_inside      = r_inside;
        n_pending     = r_pending;
        n_closed      = r_closed;
        n_field       = r_field;
        n_len         = r_len;
        n_err         = r_err;
        do_emit       = 1'b0;
        do_end        = 1'b0;
        verdict_err   = r_err;
        o_res_valid   = 1'b0;
        o_res         = '0;
        o_field_index = '0;

        if (i_eol) begin
            if (r_err == csvp_pkg::ERR_NONE) begin
                if (r_inside && !r_pending) begin
                    verdict_err = csvp_pkg::ERR_UNTERM;
                end else if (r_field != last_field) begin
                    verdict_err = csvp_pkg::ERR_COUNT;
                end
            end
            o_res_valid      = 1'b1;
            o_res.kind       = csvp_pkg::KIND_VERDICT;
            o_res.line_valid = (verdict_err == csvp_pkg::ERR_NONE);
            o_res.error_code = verdict_err;
            n_at_start       = 1'b1;
            n_inside         = 1'b0;
            n_pending        = 1'b0;
            n_closed         = 1'b0;
            n_field          = '0;
            n_len            = '0;
            n_err            = csvp_pkg::ERR_NONE;
        end else if (r_err == csvp_pkg::ERR_NONE) begin
            if (r_inside) begin
                if (r_pending) begin
                    n_pending = 1'b0;
                    if (i_byte == csvp_pkg::CH_QUOTE) begin
                        do_emit = 1'b1;
                    end else begin
                        n_inside = 1'b0;
                        n_closed = 1'b1;
                        if (i_byte == csvp_pkg::CH_COMMA) begin
                            do_end = 1'b1;
                        end else begin
                            n_err = csvp_pkg::ERR_AFTER_QT;
                        end
                    end
                end else if (i_byte == csvp_pkg::CH_QUOTE) begin
                    n_pending = 1'b1;
                end else begin
                    do_emit = 1'b1;
                end
            end else if (r_closed) begin
                if (i_byte == csvp_pkg::CH_COMMA) begin
                    do_end = 1'b1;
                end else begin
                    n_err = csvp_pkg::ERR_AFTER_QT;
                end
            end else if (i_byte == csvp_pkg::CH_COMMA) begin
                do_end = 1'b1;
            end else if (i_byte == csvp_pkg::CH_QUOTE) begin
                if (r_at_start) begin
                    n_at_start = 1'b0;
                    n_inside   = 1'b1;
                end else begin
                    n_err = csvp_pkg::ERR_STRAY;
                end
            end else begin
                do_emit = 1'b1;
            end

            if (do_emit) begin
                if (r_len >= eff_max) begin
                    n_err = csvp_pkg::ERR_TOO_LONG;
                end else begin
                    n_len          = r_len + LW'(1);
                    n_at_start     = 1'b0;
                    o_res_valid    = 1'b1;
                    o_res.kind     = csvp_pkg::KIND_BYTE;
                    o_res.out_byte = i_byte;
                    o_field_index  = r_field;
                end
            end

            if (do_end) begin
                if (r_field >= last_field) begin
                    n_err = csvp_pkg::ERR_COUNT;
                end else begin
                    n_field       = r_field + IDXW'(1);
                    n_len         = '0;
                    n_at_start    = 1'b1;
                    n_inside      = 1'b0;
                    n_pending     = 1'b0;
                    n_closed      = 1'b0;
                    o_res_valid   = 1'b1;
                    o_res.kind    = csvp_pkg::KIND_FEND;
                    o_field_index = r_field;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_inside   <= 1'b0;
            r_pending  <= 1'b0;
            r_closed   <= 1'b0;
            r_field    <= '0;
            r_len      <= '0;
            r_err      <= csvp_pkg::ERR_NONE;
        end else if (i_step) begin
            r_at_start <= n_at_start;
            r_inside   <= n_inside;
            r_pending  <= n_pending;
            r_closed   <= n_closed;
            r_field    <= n_field;
            r_len      <= n_len;
            r_err      <= n_err;
        end
    end

endmodule

FILE: rtl/csv_quoted_field_parser.sv
// CSV line parser, top level. Takes one byte or end-of-line marker per transfer and gives at
// most one result per transfer: a field byte, a field-end mark or a line verdict. The block
// accepts a transfer every cycle while o_stall is low; each passes through an input register,
// the parse logic against the per-line state, and an output register, from which the result is
// offered at the output. Throughput is one item per cycle when the output side is not stalled.
// Configure field_count and max_field_bytes over APB only while no line is in flight.
`include "csv_quoted_field_parser_defines.svh"

module csv_quoted_field_parser #(
    parameter int MAX_FIELDS        = 16,
    parameter int FIELD_BYTES_LIMIT = 2047,
    localparam int IDXW = $clog2(MAX_FIELDS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_in_byte,
    input  logic            i_end_of_line,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [1:0]      o_kind,
    output logic [IDXW-1:0] o_field_index,
    output logic [7:0]      o_out_byte,
    output logic            o_line_valid,
    output logic [2:0]      o_error_code,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    csvp_pkg::t_cfg    cfg;
    csvp_pkg::t_result res;
    logic              res_valid;
    logic [IDXW-1:0]   res_idx;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_eol;
    logic              r_out_valid;
    csvp_pkg::t_result r_out;
    logic [IDXW-1:0]   r_out_idx;

    logic              advance;
    logic              accept;

    csvp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    csvp_core #(
        .MAX_FIELDS        (MAX_FIELDS),
        .FIELD_BYTES_LIMIT (FIELD_BYTES_LIMIT)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_byte        (r_in_byte),
        .i_eol         (r_in_eol),
        .i_cfg         (cfg),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .o_field_index (res_idx)
    );

    // advance the held item once the output register is free or being drained
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in_byte;
            r_in_eol  <= i_end_of_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out     <= res;
            r_out_idx <= res_idx;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_field_index = r_out_idx;
    assign o_out_byte    = r_out.out_byte;
    assign o_line_valid  = r_out.line_valid;
    assign o_error_code  = r_out.error_code;

    `CSVP_ASSERT_IMP(a_verdict_idx_zero, o_valid && o_kind == csvp_pkg::KIND_VERDICT, o_field_index == '0)
    `CSVP_ASSERT_IMP(a_verdict_flag_matches, o_valid && o_kind == csvp_pkg::KIND_VERDICT, o_line_valid == (o_error_code == csvp_pkg::ERR_NONE))
    `CSVP_ASSERT_IMP(a_kind_legal, o_valid, o_kind != 2'd3)
    `CSVP_ASSERT_NXT(a_held_input_kept, r_in_valid && !advance, r_in_valid)

endmodule
